// File: sv/vtt_pkg.sv
// ----------------------------------------------------------------------------
// vtt_pkg
// shared widths and latencies for the velocity-toward-target pipeline
// ----------------------------------------------------------------------------
package vtt_pkg;
    localparam int COORD_W = 16;
    localparam int DELTA_W = 17;
    localparam int SPEED_W = 16;
    localparam int VEL_W   = 18;
    localparam int D2_W    = 34;
    localparam int RAD_PAD = 16;
    localparam int ROOT_W  = 25;
    localparam int PROD_W  = 33;
    localparam int NUM_W   = 41;
    localparam int QUO_W   = 16;
    localparam int SQ_LAT  = ROOT_W;
    localparam int DIV_LAT = QUO_W;
    localparam int PRE_LAT = 3;
    localparam int TOT_LAT = PRE_LAT + SQ_LAT + DIV_LAT + 1;
endpackage

// File: sv/vtt_isqrt.sv
// ----------------------------------------------------------------------------
// vtt_isqrt
// pipelined integer square root of (d2 * 2^16), one root bit per stage
// ----------------------------------------------------------------------------
module vtt_isqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [vtt_pkg::D2_W-1:0]     i_d2,
    output logic [vtt_pkg::ROOT_W-1:0]   o_root
);
    localparam int RW  = vtt_pkg::ROOT_W;
    localparam int REM = RW + 3;

    logic [REM-1:0]           r_rem  [RW];
    logic [RW-1:0]            r_root [RW];
    logic [vtt_pkg::D2_W-1:0] r_d2   [RW];

    genvar s;
    generate
        for (s = 0; s < RW; s++) begin : g_stage
            localparam int HI = 2 * RW - 1 - 2 * s;
            logic [REM-1:0] rem_in;
            logic [RW-1:0]  root_in;
            logic [vtt_pkg::D2_W-1:0] d2_in;
            logic [1:0]     pair;
            logic [REM-1:0] cur;
            logic [REM-1:0] trial;
            if (s == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign d2_in   = i_d2;
            end else begin : g_next
                assign rem_in  = r_rem[s-1];
                assign root_in = r_root[s-1];
                assign d2_in   = r_d2[s-1];
            end
            if (HI >= vtt_pkg::RAD_PAD) begin : g_pair
                assign pair = d2_in[HI-vtt_pkg::RAD_PAD -: 2];
            end else begin : g_zero
                assign pair = 2'b00;
            end
            assign cur   = {rem_in[REM-3:0], pair};
            assign trial = {1'b0, root_in, 2'b01};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d2[s] <= d2_in;
                    if (cur >= trial) begin
                        r_rem[s]  <= cur - trial;
                        r_root[s] <= {root_in[RW-2:0], 1'b1};
                    end else begin
                        r_rem[s]  <= cur;
                        r_root[s] <= {root_in[RW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[RW-1];
endmodule

// File: sv/vtt_div.sv
// ----------------------------------------------------------------------------
// vtt_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module vtt_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [vtt_pkg::NUM_W-1:0]    i_num,
    input  logic [vtt_pkg::ROOT_W-1:0]   i_den,
    output logic [vtt_pkg::QUO_W-1:0]    o_quo
);
    localparam int QW = vtt_pkg::QUO_W;
    localparam int DW = vtt_pkg::ROOT_W;

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [QW-1:0] lo_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [DW:0]   cur;
            if (j == 0) begin : g_first
                assign rem_in = i_num[vtt_pkg::NUM_W-1:QW];
                assign lo_in  = i_num[QW-1:0];
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[j-1];
                assign lo_in  = r_lo[j-1];
                assign den_in = r_den[j-1];
                assign quo_in = r_quo[j-1];
            end
            assign cur = {rem_in, lo_in[QW-1-j]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lo[j]  <= lo_in;
                    r_den[j] <= den_in;
                    if (cur >= {1'b0, den_in}) begin
                        r_rem[j] <= DW'(cur - {1'b0, den_in});
                        r_quo[j] <= {quo_in[QW-2:0], 1'b1};
                    end else begin
                        r_rem[j] <= cur[DW-1:0];
                        r_quo[j] <= {quo_in[QW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW-1];
endmodule

// File: sv/velocity_toward_target_top.sv
// ----------------------------------------------------------------------------
// velocity_toward_target_top
// per-tick velocity of magnitude speed pointing from start to destination
// ----------------------------------------------------------------------------
// One item per clock cycle is accepted while the pipeline advances and one
// result comes out per item, through 45 register stages: three stages of
// delta, product and sum, 25 stages in the bit-per-stage square root, 16
// stages in the two bit-per-stage dividers and one output register. The
// whole pipeline advances together and holds only while a result waits at
// the output and i_ready is low.
module velocity_toward_target_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [vtt_pkg::COORD_W-1:0]  i_start_x,
    input  logic signed [vtt_pkg::COORD_W-1:0]  i_start_y,
    input  logic signed [vtt_pkg::COORD_W-1:0]  i_dest_x,
    input  logic signed [vtt_pkg::COORD_W-1:0]  i_dest_y,
    input  logic        [vtt_pkg::SPEED_W-1:0]  i_speed,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [vtt_pkg::VEL_W-1:0]    o_vel_x,
    output logic signed [vtt_pkg::VEL_W-1:0]    o_vel_y,
    output logic                                o_no_motion
);
    localparam int DW  = vtt_pkg::DELTA_W;
    localparam int PW  = vtt_pkg::PROD_W;
    localparam int TL  = vtt_pkg::TOT_LAT;
    localparam int SL  = vtt_pkg::SQ_LAT;
    localparam int FL  = vtt_pkg::SQ_LAT + vtt_pkg::DIV_LAT;

    logic en;
    logic [TL-1:0] r_v;

    // stage 1: deltas
    logic [DW-1:0] r_ax, r_ay;
    logic          r_sx1, r_sy1;
    logic [vtt_pkg::SPEED_W-1:0] r_spd1;
    logic signed [DW-1:0] dx, dy;
    // stage 2: products
    logic [2*DW-1:0] r_sqx, r_sqy;
    logic [PW-1:0]   r_px2, r_py2;
    logic            r_sx2, r_sy2, r_sz2;
    // stage 3: sum of squares
    logic [vtt_pkg::D2_W-1:0] r_d2;
    logic [PW-1:0]   r_px3, r_py3;
    logic            r_sx3, r_sy3, r_z3;
    // side delay lines
    logic [PW-1:0]   r_pxd [SL];
    logic [PW-1:0]   r_pyd [SL];
    logic [2:0]      r_fl  [FL];
    logic [vtt_pkg::ROOT_W-1:0] root;
    logic [vtt_pkg::QUO_W-1:0]  qx, qy;
    logic [vtt_pkg::VEL_W-1:0]  mx, my;
    logic [2:0]      fl_out;

    assign en      = ~r_v[TL-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_v[TL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[TL-2:0], i_valid};
        end
    end

    assign dx = DW'(i_dest_x) - DW'(i_start_x);
    assign dy = DW'(i_dest_y) - DW'(i_start_y);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx1  <= dx[DW-1];
            r_sy1  <= dy[DW-1];
            r_ax   <= dx[DW-1] ? DW'(-dx) : dx;
            r_ay   <= dy[DW-1] ? DW'(-dy) : dy;
            r_spd1 <= i_speed;

            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_px2 <= r_ax * r_spd1;
            r_py2 <= r_ay * r_spd1;
            r_sx2 <= r_sx1;
            r_sy2 <= r_sy1;
            r_sz2 <= (r_spd1 == '0) || ((r_ax == '0) && (r_ay == '0));

            r_d2  <= vtt_pkg::D2_W'(r_sqx) + vtt_pkg::D2_W'(r_sqy);
            r_px3 <= r_px2;
            r_py3 <= r_py2;
            r_sx3 <= r_sx2;
            r_sy3 <= r_sy2;
            r_z3  <= r_sz2;

            r_pxd[0] <= r_px3;
            r_pyd[0] <= r_py3;
            for (int k = 1; k < SL; k++) begin
                r_pxd[k] <= r_pxd[k-1];
                r_pyd[k] <= r_pyd[k-1];
            end
            r_fl[0] <= {r_z3, r_sy3, r_sx3};
            for (int k = 1; k < FL; k++) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    vtt_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_d2   (r_d2),
        .o_root (root)
    );

    vtt_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r_pxd[SL-1], 8'b0}),
        .i_den (root),
        .o_quo (qx)
    );

    vtt_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r_pyd[SL-1], 8'b0}),
        .i_den (root),
        .o_quo (qy)
    );

    assign fl_out = r_fl[FL-1];
    assign mx     = vtt_pkg::VEL_W'(qx);
    assign my     = vtt_pkg::VEL_W'(qy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_no_motion <= fl_out[2];
            if (fl_out[2]) begin
                o_vel_x <= '0;
                o_vel_y <= '0;
            end else begin
                o_vel_x <= fl_out[0] ? -mx : mx;
                o_vel_y <= fl_out[1] ? -my : my;
            end
        end
    end

    // a stopped object never reports a velocity
    a_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_motion |-> (o_vel_x == '0) && (o_vel_y == '0))
        else $error("no_motion with nonzero velocity");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v[0])
        else $error("accepted item lost at entry");

    // pipeline freezes while the output is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_vel_x) && $stable(o_vel_y))
        else $error("held result changed");
endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// random and directed check of the velocity-toward-target pipeline: every
// accepted item is predicted in the scoreboard and each result is compared
// against the oldest pending velocity, with random idling on both sides
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [vtt_pkg::VEL_W-1:0] vx;
        logic signed [vtt_pkg::VEL_W-1:0] vy;
        logic                             still;
    } t_velocity;

    class t_velocity_board;
        t_velocity pending[$];
        int        errors;

        function automatic logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bitv;
            res = 0;
            bitv = 64'd1 << 48;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function void note_item(logic signed [15:0] sx, logic signed [15:0] sy,
                                logic signed [15:0] ex, logic signed [15:0] ey,
                                logic [15:0] spd);
            longint    dx, dy;
            logic [63:0] ax, ay, radius, mx, my;
            t_velocity v;
            dx = longint'(ex) - longint'(sx);
            dy = longint'(ey) - longint'(sy);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            radius = root_floor((ax * ax + ay * ay) << 16);
            if (spd == 0 || radius == 0) begin
                v = '{vx: '0, vy: '0, still: 1'b1};
            end else begin
                mx = ((ax * spd) << 8) / radius;
                my = ((ay * spd) << 8) / radius;
                v.vx = dx < 0 ? -mx[vtt_pkg::VEL_W-1:0] : mx[vtt_pkg::VEL_W-1:0];
                v.vy = dy < 0 ? -my[vtt_pkg::VEL_W-1:0] : my[vtt_pkg::VEL_W-1:0];
                v.still = 1'b0;
            end
            pending.push_back(v);
        endfunction

        function void check_result(t_velocity got);
            t_velocity want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result vx=%0d vy=%0d nm=%0b",
                                           got.vx, got.vy, got.still);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected vx=%0d vy=%0d nm=%0b, got vx=%0d vy=%0d nm=%0b",
                             want.vx, want.vy, want.still, got.vx, got.vy, got.still);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [15:0] i_start_x = '0, i_start_y = '0, i_dest_x = '0, i_dest_y = '0;
    logic [15:0] i_speed = '0;
    logic o_ready, o_valid, o_no_motion;
    logic signed [vtt_pkg::VEL_W-1:0] o_vel_x, o_vel_y;

    t_velocity_board board = new();
    int send_idle = 28, recv_idle = 54;
    bit hold_recv = 0;
    bit sending_done = 0;
    longint cycles = 0;

    velocity_toward_target_top uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver side
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result('{vx: o_vel_x, vy: o_vel_y, still: o_no_motion});
    end

    always @(negedge i_clk) begin
        if (hold_recv) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_item(logic signed [15:0] sx, logic signed [15:0] sy,
                             logic signed [15:0] ex, logic signed [15:0] ey,
                             logic [15:0] spd);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_x <= sx; i_start_y <= sy; i_dest_x <= ex; i_dest_y <= ey; i_speed <= spd;
        do @(posedge i_clk); while (!o_ready);
        board.note_item(sx, sy, ex, ey, spd);
        @(negedge i_clk);
    endtask

    task automatic send_random(int n);
        logic signed [15:0] sx, sy;
        for (int k = 0; k < n; k++) begin
            sx = $urandom;
            sy = $urandom;
            case ($urandom_range(5))
                0: send_item(sx, sy, $urandom, $urandom, $urandom);
                1: send_item(sx, sy, sx + $signed(16'($urandom_range(64))) - 16'sd32,
                             sy + $signed(16'($urandom_range(64))) - 16'sd32, $urandom);
                2: send_item(sx, sy, sx, sy, $urandom);
                3: send_item(sx, sy, $urandom, $urandom, 16'($urandom_range(3)));
                default: send_item($urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
        end
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // extremes, zero speed, zero distance, axis-aligned and diagonal moves
        send_item(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff);
        send_item(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'hffff);
        send_item(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'h0100);
        send_item(16'sh1234, 16'sh0042, 16'sh1234, 16'sh0042, 16'hffff);
        send_item(16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000, 16'h0000);
        send_item(16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000, 16'h0001);
        send_item(16'sh0000, 16'sh0000, 16'sh0000, -16'sh0001, 16'hffff);
        send_item(16'sh0000, 16'sh0000, 16'sh0030, 16'sh0040, 16'h0500);
        send_item(16'sh0000, 16'sh0000, -16'sh0030, -16'sh0040, 16'h0500);
        send_item(16'sh0000, 16'sh0000, 16'sh0001, 16'sh0001, 16'h8000);
        send_item(16'sh8000, 16'sh0000, 16'sh8000, 16'sh7fff, 16'h0001);
        send_item(16'shffff, 16'shffff, 16'sh0000, 16'sh0000, 16'h00ff);
        send_random(150);
        drain();
        // long receiver hold-off so the pipeline fills and stalls its input
        fork
            begin
                hold_recv = 1;
                repeat (200) @(negedge i_clk);
                hold_recv = 0;
            end
            begin
                send_idle = 0;
                send_random(80);
            end
        join
        drain();
        send_idle = 54; recv_idle = 28;
        send_random(110);
        send_idle = 0; recv_idle = 0;
        send_random(110);
        drain();
        repeat (vtt_pkg::TOT_LAT + 10) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
